// File: hdl/averaged_light_switch_top_defines.svh
// assertion macros for the averaged light switch
`ifndef AVERAGED_LIGHT_SWITCH_TOP_DEFINES_SVH
`define AVERAGED_LIGHT_SWITCH_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
`define ALS_ASSERT_NOW(label, clk_sig, rstn_sig, ante, cons, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |-> (cons)) \
        else $error(msg);
`define ALS_ASSERT_NEXT(label, clk_sig, rstn_sig, ante, cons, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ALS_ASSERT_NOW(label, clk_sig, rstn_sig, ante, cons, msg)
`define ALS_ASSERT_NEXT(label, clk_sig, rstn_sig, ante, cons, msg)
`endif

`endif

// File: hdl/als_pkg.sv
package als_pkg;

    localparam int WINDOW_LEN   = 16;
    localparam int SAMPLE_BITS  = 12;
    localparam int LEVEL_BITS   = 12;
    localparam int PTR_BITS     = $clog2(WINDOW_LEN);
    localparam int CNT_BITS     = $clog2(WINDOW_LEN + 1);
    localparam int SUM_BITS     = SAMPLE_BITS + PTR_BITS;
    localparam int DIV_BITS     = PTR_BITS + 1;
    localparam int STEP_BITS    = $clog2(SUM_BITS);
    localparam int CFG_IDX_BITS = 1;

    localparam logic [LEVEL_BITS-1:0] DARK_RESET  = LEVEL_BITS'(2000);
    localparam logic [LEVEL_BITS-1:0] LIGHT_RESET = LEVEL_BITS'(2400);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_DARK_LEVEL  = 1'b0,
        REG_LIGHT_LEVEL = 1'b1
    } als_reg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_DIVIDE,
        ST_FINISH
    } als_state_t;

    typedef struct packed {
        logic load;
        logic update;
        logic div_step;
        logic finish;
    } als_cmd_t;

    typedef struct packed {
        logic out_free;
    } als_status_t;

endpackage

// File: hdl/als_datapath.sv
`include "averaged_light_switch_top_defines.svh"

module als_datapath
    import als_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  als_cmd_t                cmd,
    output als_status_t             status,
    input  logic [SAMPLE_BITS-1:0]  sample,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [LEVEL_BITS-1:0]   cfg_data,
    input  logic                    out_ready,
    output logic                    out_valid,
    output logic [SAMPLE_BITS-1:0]  average,
    output logic                    lamp_on
);

    logic [SAMPLE_BITS-1:0] ring_reg [WINDOW_LEN];
    logic [SAMPLE_BITS-1:0] sample_reg;
    logic [SUM_BITS-1:0]    sum_reg;
    logic [SUM_BITS-1:0]    sum_next;
    logic [PTR_BITS-1:0]    slot_reg;
    logic [PTR_BITS-1:0]    slot_next;
    logic [CNT_BITS-1:0]    fill_reg;
    logic [CNT_BITS-1:0]    fill_next;
    logic [LEVEL_BITS-1:0]  dark_reg;
    logic [LEVEL_BITS-1:0]  light_reg;
    logic [SUM_BITS-1:0]    quo_reg;
    logic [SUM_BITS-1:0]    quo_next;
    logic [PTR_BITS-1:0]    rem_reg;
    logic [PTR_BITS-1:0]    rem_next;
    logic [DIV_BITS-1:0]    rem_shift;
    logic [DIV_BITS-1:0]    divisor;
    logic [DIV_BITS-1:0]    rem_diff;
    logic                   lamp_reg;
    logic                   lamp_next;
    logic [SAMPLE_BITS-1:0] avg;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [SAMPLE_BITS-1:0] average_reg;
    logic                   lamp_out_reg;

    // ring update and running sum
    always_comb
    begin
        sum_next = sum_reg - SUM_BITS'(ring_reg[slot_reg]) + SUM_BITS'(sample_reg);
        if (slot_reg == PTR_BITS'(WINDOW_LEN - 1))
            slot_next = '0;
        else
            slot_next = slot_reg + 1'b1;
        if (fill_reg < CNT_BITS'(WINDOW_LEN))
            fill_next = fill_reg + 1'b1;
        else
            fill_next = fill_reg;
    end

    // restoring divide, one quotient bit per step
    always_comb
    begin
        divisor   = DIV_BITS'(fill_reg);
        rem_shift = {rem_reg, quo_reg[SUM_BITS-1]};
        rem_diff  = rem_shift - divisor;
        if (rem_shift >= divisor)
        begin
            rem_next = rem_diff[PTR_BITS-1:0];
            quo_next = {quo_reg[SUM_BITS-2:0], 1'b1};
        end
        else
        begin
            rem_next = rem_shift[PTR_BITS-1:0];
            quo_next = {quo_reg[SUM_BITS-2:0], 1'b0};
        end
    end

    // hysteresis, dark test first
    always_comb
    begin
        avg = quo_reg[SAMPLE_BITS-1:0];
        if (avg < dark_reg)
            lamp_next = 1'b1;
        else if (avg > light_reg)
            lamp_next = 1'b0;
        else
            lamp_next = lamp_reg;
    end

    always_comb
    begin
        if (cmd.finish)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign status.out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW_LEN; i++)
                ring_reg[i] <= '0;
            sum_reg       <= '0;
            slot_reg      <= '0;
            fill_reg      <= '0;
            lamp_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            dark_reg      <= DARK_RESET;
            light_reg     <= LIGHT_RESET;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cmd.update)
            begin
                ring_reg[slot_reg] <= sample_reg;
                sum_reg            <= sum_next;
                slot_reg           <= slot_next;
                fill_reg           <= fill_next;
            end
            if (cmd.finish)
                lamp_reg <= lamp_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_DARK_LEVEL:  dark_reg  <= cfg_data;
                    REG_LIGHT_LEVEL: light_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            sample_reg <= sample;
        if (cmd.update)
        begin
            quo_reg <= sum_next;
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
        if (cmd.finish)
        begin
            average_reg  <= avg;
            lamp_out_reg <= lamp_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign average   = average_reg;
    assign lamp_on   = lamp_out_reg;

    `ALS_ASSERT_NOW(a_fill_bound, clk, rst_n, 1'b1, fill_reg <= CNT_BITS'(WINDOW_LEN), "fill count beyond window")
    `ALS_ASSERT_NOW(a_rem_below_div, clk, rst_n, cmd.div_step, DIV_BITS'(rem_reg) < divisor, "divider remainder not below divisor")
    `ALS_ASSERT_NEXT(a_finish_valid, clk, rst_n, cmd.finish, out_valid_reg && fill_reg != '0, "finished request not presented")

endmodule

// File: hdl/als_ctrl.sv
module als_ctrl
    import als_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  als_status_t status,
    output als_cmd_t    cmd
);

    als_state_t           state_reg;
    als_state_t           state_next;
    logic [STEP_BITS-1:0] step_reg;
    logic [STEP_BITS-1:0] step_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                step_next  = '0;
                state_next = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (step_reg == STEP_BITS'(SUM_BITS - 1))
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: hdl/averaged_light_switch_top.sv
// sequence: the result is registered after the ST_UPDATE, ST_DIVIDE and ST_FINISH
// states in that order; ST_FINISH waits while the output register is still held by the sink
// requests: no new request is taken until the previous one has finished; divide by a 16-step restoring divider
// reset: asynchronous, active low; sample ring, sum and fill count cleared,
// lamp state off (lamp_on output register not reset), thresholds 2000 and 2400
module averaged_light_switch_top
    import als_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [SAMPLE_BITS-1:0]  sample,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [SAMPLE_BITS-1:0]  average,
    output logic                    lamp_on,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [LEVEL_BITS-1:0]   cfg_data
);

    als_cmd_t    cmd;
    als_status_t status;

    als_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    als_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .sample    (sample),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .average   (average),
        .lamp_on   (lamp_on)
    );

endmodule
